/* rtl/core/multitap_echo_delay_line_defines.svh */
// ---------------------------------------------------------------------------
// multitap_echo_delay_line_defines.svh
// Assertion macros for the multitap echo delay line.
// ---------------------------------------------------------------------------
`ifndef MULTITAP_ECHO_DELAY_LINE_DEFINES_SVH
`define MULTITAP_ECHO_DELAY_LINE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a boolean property at every clock edge outside reset.
`define MTED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// Check that the consequent holds in the same cycle as the antecedent.
`define MTED_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define MTED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MTED_ASSERT(label, prop, msg)
`define MTED_ASSERT_IMPL(label, ante, cons, msg)
`define MTED_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/core/mted_pkg.sv */
// ---------------------------------------------------------------------------
// mted_pkg
// Shared constants, types and helpers of the multitap echo delay line.
// ---------------------------------------------------------------------------
package mted_pkg;

  localparam int unsigned DELAY_LENGTH = 4096;
  localparam int unsigned TAP_COUNT    = 4;
  localparam int unsigned ADDR_W       = $clog2(DELAY_LENGTH);
  localparam int unsigned FILL_W       = ADDR_W + 1;
  localparam int unsigned TAP_W        = 2;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned DELAY_W      = 12;
  localparam int unsigned CFG_IDX_W    = 3;

  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAP_COUNT - 1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TAP0_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP3_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP0_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP3_GAIN  = 3'd7;

  localparam logic [DELAY_W-1:0] DELAY_RESET [4] = '{
    12'd1024, 12'd1536, 12'd2560, 12'd3072
  };
  localparam logic [SAMPLE_W-1:0] GAIN_RESET [4] = '{
    32'sd536870912, 32'sd268435456, 32'sd134217728, 32'sd134217728
  };

  localparam logic [SAMPLE_W-1:0] Q31_MAX = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] Q31_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAP,
    ST_DRAIN_MUL,
    ST_DRAIN_ACC,
    ST_FINISH
  } mted_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [TAP_W-1:0] rd_tap;
    logic             push;
  } mted_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } mted_status_t;

  // Clamp a 33-bit signed value into the Q1.31 range.
  function automatic logic [SAMPLE_W-1:0] sat_q31(logic [SAMPLE_W:0] v);
    logic [SAMPLE_W-1:0] r;
    if (v[SAMPLE_W] != v[SAMPLE_W-1]) begin
      r = v[SAMPLE_W] ? Q31_MIN : Q31_MAX;
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/multitap_echo_delay_line.sv */
// Sequence: after a sample transfer, one tap per cycle is read from the single read port
// of the delay store and weighted through the shared multiplier; the pipeline then drains
// and the sum goes to the output register, later while the previous result is still
// stalled at the output. The next sample is stalled until the sum has been pushed.
// Reset: asynchronous, active low; restores tap registers and the write index.
// The delay store needs no clearing pass: a fill count masks unwritten entries to zero.
// ---------------------------------------------------------------------------
// multitap_echo_delay_line
// Four-tap echo on a Q1.31 stream with a 4096-sample circular delay store.
// ---------------------------------------------------------------------------
`include "multitap_echo_delay_line_defines.svh"

module multitap_echo_delay_line (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mted_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mted_pkg::SAMPLE_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [mted_pkg::SAMPLE_W-1:0] input_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [mted_pkg::SAMPLE_W-1:0] output_sample_o
);

  import mted_pkg::*;

  mted_cmd_t    cmd;
  mted_status_t status;

  assign cfg_ready_o = 1'b1;

  mted_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mted_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .input_sample_i  (input_sample_i),
    .output_sample_o (output_sample_o),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .cmd_i           (cmd),
    .status_o        (status)
  );

  // a transfer in starts the sequence, so the next sample must wait
  `MTED_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o, "input taken while busy")
  // never overwrite a result that is still held
  `MTED_ASSERT_IMPL(a_no_overwrite, cmd.push, !(out_valid_o && out_stall_i), "held result overwritten")
  // a new result only appears after a push
  `MTED_ASSERT_IMPL(a_valid_from_push, $rose(out_valid_o), $past(cmd.push), "result without push")

endmodule

/* rtl/core/mted_ram.sv */
// ---------------------------------------------------------------------------
// mted_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mted_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mted_ctrl.sv */
// ---------------------------------------------------------------------------
// mted_ctrl
// Sequencer: accept a sample, issue one tap read per cycle, drain, push.
// ---------------------------------------------------------------------------
module mted_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mted_pkg::mted_status_t status_i,
  output mted_pkg::mted_cmd_t    cmd_o
);

  import mted_pkg::*;

  mted_state_e      state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_TAP;
          tap_d   = '0;
        end
      end
      ST_TAP: begin
        if (tap_q == TAP_LAST) begin
          state_d = ST_DRAIN_MUL;
        end else begin
          tap_d = tap_q + 1'b1;
        end
      end
      ST_DRAIN_MUL: state_d = ST_DRAIN_ACC;
      ST_DRAIN_ACC: state_d = ST_FINISH;
      ST_FINISH: begin
        // hold the sum until the output register frees up
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o   = 1'b1;
    cmd_o.load   = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.rd_tap = tap_q;
    cmd_o.push   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_TAP:    cmd_o.rd_en = 1'b1;
      ST_FINISH: cmd_o.push  = !status_i.out_busy;
      default: ;
    endcase
  end

endmodule

/* rtl/core/mted_dp.sv */
// ---------------------------------------------------------------------------
// mted_dp
// Datapath: tap registers, delay store, shared multiplier, accumulator.
// ---------------------------------------------------------------------------
module mted_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [mted_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mted_pkg::SAMPLE_W-1:0]        cfg_data_i,
  input  logic signed [mted_pkg::SAMPLE_W-1:0] input_sample_i,
  output logic signed [mted_pkg::SAMPLE_W-1:0] output_sample_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  input  mted_pkg::mted_cmd_t                  cmd_i,
  output mted_pkg::mted_status_t               status_o
);

  import mted_pkg::*;

  logic [DELAY_W-1:0]  delay_q [4];
  logic [SAMPLE_W-1:0] gain_q  [4];

  logic [ADDR_W-1:0]   wr_idx_q, cur_w_q;
  logic [FILL_W-1:0]   fill_q;

  logic [ADDR_W-1:0]   rd_addr;
  logic [DELAY_W-1:0]  rd_delay;
  logic                rd_vld_q, mask_q, mul_vld_q;
  logic [TAP_W-1:0]    rd_tap_q;
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] tap_sample;
  logic signed [2*SAMPLE_W-1:0] prod_q;
  logic [SAMPLE_W-1:0] term;
  logic [SAMPLE_W:0]   sum;
  logic [SAMPLE_W-1:0] acc_q;
  logic [SAMPLE_W-1:0] out_q;
  logic                out_vld_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        delay_q[i] <= DELAY_RESET[i];
        gain_q[i]  <= GAIN_RESET[i];
      end
    end else if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_index_i inside {[CFG_TAP0_DELAY:CFG_TAP3_DELAY]}) begin
        delay_q[cfg_index_i[TAP_W-1:0]] <= cfg_data_i[DELAY_W-1:0];
      end else if (cfg_index_i inside {[CFG_TAP0_GAIN:CFG_TAP3_GAIN]}) begin
        gain_q[cfg_index_i[TAP_W-1:0]] <= cfg_data_i;
      end
    end
  end

  // Write pointer and fill count; entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= ADDR_W'(DELAY_LENGTH - 1);
      fill_q   <= '0;
    end else if (cmd_i.load) begin
      wr_idx_q <= (wr_idx_q == ADDR_W'(DELAY_LENGTH - 1)) ? '0 : wr_idx_q + 1'b1;
      if (fill_q != FILL_W'(DELAY_LENGTH)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign rd_delay = delay_q[cmd_i.rd_tap];
  assign rd_addr  = cur_w_q - ADDR_W'(rd_delay);

  mted_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (wr_idx_q),
    .wdata_i (input_sample_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // Pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.rd_en;
      mul_vld_q <= rd_vld_q;
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign tap_sample = mask_q ? rdata : '0;
  assign term       = sat_q31(prod_q[2*SAMPLE_W-1:SAMPLE_W-1]);
  assign sum        = {acc_q[SAMPLE_W-1], acc_q} + {term[SAMPLE_W-1], term};

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_w_q <= wr_idx_q;
      // half of the input: floor shift by one
      acc_q   <= {input_sample_i[SAMPLE_W-1], input_sample_i[SAMPLE_W-1:1]};
    end else if (mul_vld_q) begin
      acc_q   <= sat_q31(sum);
    end
    if (cmd_i.rd_en) begin
      rd_tap_q <= cmd_i.rd_tap;
      mask_q   <= (FILL_W'(rd_delay) < fill_q);
    end
    if (rd_vld_q) begin
      prod_q <= $signed(gain_q[rd_tap_q]) * $signed(tap_sample);
    end
    if (cmd_i.push) begin
      out_q <= acc_q;
    end
  end

  assign output_sample_o   = out_q;
  assign out_valid_o       = out_vld_q;
  assign status_o.out_busy = out_vld_q && out_stall_i;

endmodule

/* tb/sv/multitap_echo_delay_line_checker.sv */
// ---------------------------------------------------------------------------
// multitap_echo_delay_line_checker
// Watches the register, sample and echo channels of the echo delay line,
// keeps its own copy of the delay store and tap registers, and compares
// every echo transfer with the oldest predicted value.
// ---------------------------------------------------------------------------
module multitap_echo_delay_line_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [mted_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mted_pkg::SAMPLE_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic signed [mted_pkg::SAMPLE_W-1:0] input_sample_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [mted_pkg::SAMPLE_W-1:0] output_sample_i,
  output int                                   mismatch_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mted_pkg::*;

  localparam longint Q31_HALF  = 64'sd1073741824;
  localparam longint Q31_UPPER = 64'sd2147483647;
  localparam longint Q31_LOWER = -64'sd2147483648;

  logic [SAMPLE_W-1:0]        echo_store [DELAY_LENGTH];
  logic [ADDR_W-1:0]          wr_ptr;
  logic [DELAY_W-1:0]         tap_delay [4];
  logic signed [SAMPLE_W-1:0] tap_weight [4];
  logic signed [SAMPLE_W-1:0] echo_expected_q [$];
  int                         mismatches = 0;

  function automatic longint q31_clamp(longint v);
    if (v > Q31_UPPER) begin
      return Q31_UPPER;
    end
    if (v < Q31_LOWER) begin
      return Q31_LOWER;
    end
    return v;
  endfunction

  // Arithmetic shift of the exact product floors, as truncation does.
  function automatic longint q31_mul(longint a, longint b);
    longint p;
    p = a * b;
    return q31_clamp(p >>> 31);
  endfunction

  // Store the sample, advance the write pointer, and sum half the sample with the four taps.
  function automatic logic signed [SAMPLE_W-1:0] echo_next(logic signed [SAMPLE_W-1:0] x);
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] rd;
    longint            sum;
    slot             = wr_ptr;
    echo_store[slot] = x;
    wr_ptr           = slot + 1'b1;
    sum              = q31_mul(longint'(x), Q31_HALF);
    for (int t = 0; t < TAP_COUNT; t++) begin
      rd  = slot - tap_delay[t];
      sum = q31_clamp(sum + q31_mul(longint'($signed(echo_store[rd])), longint'(tap_weight[t])));
    end
    return sum[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_ni) begin
      foreach (echo_store[k]) begin
        echo_store[k] = '0;
      end
      wr_ptr = '1;
      for (int t = 0; t < 4; t++) begin
        tap_delay[t]  = DELAY_RESET[t];
        tap_weight[t] = GAIN_RESET[t];
      end
      echo_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (echo_expected_q.size() == 0) begin
          $display("%0t: output_sample 0x%08h transfer with no sample pending",
                   $time, output_sample_i);
          mismatches++;
        end else begin
          want = echo_expected_q.pop_front();
          if (output_sample_i !== want) begin
            $display("%0t: output_sample mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                     $time, want, want, output_sample_i, output_sample_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i <= CFG_TAP3_DELAY) begin
          tap_delay[cfg_index_i[TAP_W-1:0]] = cfg_data_i[DELAY_W-1:0];
        end else if (cfg_index_i >= CFG_TAP0_GAIN && cfg_index_i <= CFG_TAP3_GAIN) begin
          tap_weight[cfg_index_i[TAP_W-1:0]] = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        echo_expected_q.push_back(echo_next(input_sample_i));
      end
      pending_o <= echo_expected_q.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

/* tb/sv/multitap_echo_delay_line_tb.sv */
// ---------------------------------------------------------------------------
// multitap_echo_delay_line_tb
// Drives directed and random Q1.31 samples and tap settings into the echo
// delay line under several idle and stall mixes; the checker beside the
// block predicts and compares every echo transfer.
// ---------------------------------------------------------------------------
module multitap_echo_delay_line_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mted_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 16;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 100;
  localparam int RUN_LIMIT_NS   = 4_000_000;

  logic                       clk_i      = 1'b0;
  logic                       rst_ni     = 1'b0;
  logic                       cfg_valid  = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index  = '0;
  logic [SAMPLE_W-1:0]        cfg_data   = '0;
  logic                       smp_valid  = 1'b0;
  logic                       smp_stall;
  logic signed [SAMPLE_W-1:0] smp_data   = '0;
  logic                       echo_valid;
  logic                       echo_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] echo_data;

  int mismatch_count;
  int pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  logic [DELAY_W-1:0]  next_delay [4];
  logic [SAMPLE_W-1:0] next_gain [4];

  multitap_echo_delay_line uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (smp_valid),
    .in_stall_o      (smp_stall),
    .input_sample_i  (smp_data),
    .out_valid_o     (echo_valid),
    .out_stall_i     (echo_stall),
    .output_sample_o (echo_data)
  );

  multitap_echo_delay_line_checker echo_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (smp_valid),
    .in_stall_i       (smp_stall),
    .input_sample_i   (smp_data),
    .out_valid_i      (echo_valid),
    .out_stall_i      (echo_stall),
    .output_sample_i  (echo_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    echo_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Upper data bits of the delay registers are random; only the low 12 count.
  task automatic apply_taps();
    for (int t = 0; t < 4; t++) begin
      write_reg(CFG_TAP0_DELAY + CFG_IDX_W'(t),
                {SAMPLE_W'($urandom()) >> DELAY_W << DELAY_W} | SAMPLE_W'(next_delay[t]));
      write_reg(CFG_TAP0_GAIN + CFG_IDX_W'(t), next_gain[t]);
    end
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    smp_valid <= 1'b1;
    smp_data  <= x;
    @(posedge clk_i);
    while (smp_stall) @(posedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      smp_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
  endtask

  // Hold the sample channel until every echo is back and the block is idle.
  task automatic drain();
    smp_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return Q31_MAX;
      1:       return Q31_MIN;
      2:       return SAMPLE_W'($signed($urandom_range(64)) - 32);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return Q31_MAX;
      1:       return Q31_MIN;
      default: return $urandom();
    endcase
  endfunction

  task automatic choose_taps(input int phase);
    for (int t = 0; t < 4; t++) begin
      if (phase == 2) begin
        // extremes: shortest and longest delays, full-scale gains
        next_delay[t] = t[0] ? {DELAY_W{1'b1}} : '0;
        next_gain[t]  = (t == 0 || t == 3) ? Q31_MAX : Q31_MIN;
      end else begin
        next_delay[t] = ($urandom_range(3) == 0) ? DELAY_W'($urandom_range(4095))
                                                  : DELAY_W'($urandom_range(24));
        next_gain[t]  = rand_gain();
      end
    end
  endtask

  initial begin
    #RUN_LIMIT_NS;
    $display("Verification failed");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset tap settings: long delays read cleared entries, half input passes.
    send_sample(Q31_MAX);
    send_sample(Q31_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(32'sd1);
    drain();

    // All taps on the newest sample with gain -1: -1 times -1 saturates,
    // and the sum saturates on both sides.
    for (int t = 0; t < 4; t++) begin
      next_delay[t] = '0;
      next_gain[t]  = Q31_MIN;
    end
    apply_taps();
    send_sample(Q31_MIN);
    send_sample(Q31_MAX);
    send_sample('1);
    send_sample('0);
    drain();

    // Short delays and the longest one, mixed gains.
    next_delay = '{12'd1, 12'd2, 12'd3, 12'd4095};
    next_gain  = '{Q31_MAX, Q31_MIN, 32'h4000_0000, 32'hC000_0000};
    apply_taps();
    send_sample(Q31_MAX);
    send_sample(Q31_MIN);
    send_sample(32'h5555_5555);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'sd1);
    send_sample('1);
    send_sample(Q31_MAX);
    send_sample(Q31_MAX);
    send_sample(Q31_MIN);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      choose_taps(p);
      apply_taps();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(rand_sample());
        if ($urandom_range(39) == 0) begin
          drain();
        end
      end
      drain();
    end

    smp_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/mted_pkg.sv
rtl/core/mted_ram.sv
rtl/core/mted_ctrl.sv
rtl/core/mted_dp.sv
rtl/core/multitap_echo_delay_line.sv
tb/sv/multitap_echo_delay_line_checker.sv
tb/sv/multitap_echo_delay_line_tb.sv
